FILE: src/argb_porter_duff_compositor_defines.svh
// Assertion macros shared by the checker of the ARGB compositor.
// Depends on nothing; every user supplies a clock named i_clk and a reset named i_rst_n.
`ifndef ARGB_PORTER_DUFF_COMPOSITOR_DEFINES_SVH
`define ARGB_PORTER_DUFF_COMPOSITOR_DEFINES_SVH

// Checked only while the block is out of reset.
`define APDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define APDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/apdc_pkg.sv
// Shared types, register indexes and arithmetic helpers of the ARGB compositor.
// Depends on nothing; used by every module of the block.
package apdc_pkg;

    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned NUM_CHAN   = 4;
    localparam int unsigned PROD_W     = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_IN      = 2'd0,
        OP_OVER    = 2'd1,
        OP_ADD     = 2'd2,
        OP_IN_OVER = 2'd3
    } t_op_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP_MODE      = 3'd0,
        CFG_USE_CONST_SRC = 3'd1,
        CFG_CONST_SRC    = 3'd2,
        CFG_USE_CONST_MSK = 3'd3,
        CFG_CONST_MSK    = 3'd4
    } t_cfg_index;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    // Control that travels down the pipeline with every beat.
    typedef struct packed {
        logic     valid;
        logic     last;
        t_op_mode mode;
    } t_ctl;

    typedef logic [NUM_CHAN-1:0][PROD_W-1:0] t_prod;

    // Divide by 255 as (x + (x >> 8)) >> 8.
    function automatic logic [8:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {9'b0, x[PROD_W-1:8]};
        return sum[PROD_W:8];
    endfunction

    function automatic logic [CHAN_W-1:0] sat8(input logic [9:0] v);
        return (v > 10'd255) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

endpackage

FILE: src/argb_porter_duff_compositor.sv
// Top level of the premultiplied ARGB compositor: configuration registers and
// the five-stage pipeline. Depends on apdc_pkg, apdc_in_stage, apdc_mask_stage, apdc_blend_stage.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid / o_in_ready, pixel fields     | into block
//   out     | o_out_valid / i_out_ready, result fields  | out of block
//   cfg     | i_cfg_valid / o_cfg_ready, index, data    | into block
//
// One pixel is accepted per cycle while the output is not stalled; each result
// passes through the five register stages (select, mask product, mask divide,
// alpha product, blend and saturate). Reset is synchronous and clears the
// valid bits and the configuration registers to their defaults. When the output beat is
// not taken, the whole pipeline holds; a free output register lets it advance.
module argb_porter_duff_compositor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [apdc_pkg::PIX_W-1:0]          i_dest_pixel,
    input  logic [apdc_pkg::PIX_W-1:0]          i_source_pixel,
    input  logic [apdc_pkg::CHAN_W-1:0]         i_coverage,
    input  logic                                i_last_in_run,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [apdc_pkg::PIX_W-1:0]          o_result_pixel,
    output logic                                o_last_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [apdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [apdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    apdc_pkg::t_op_mode                  r_op_mode;
    logic                                r_use_const_src;
    logic [apdc_pkg::PIX_W-1:0]          r_const_src;
    logic                                r_use_const_msk;
    logic [apdc_pkg::CHAN_W-1:0]         r_const_msk;

    logic                                en;
    apdc_pkg::t_ctl                      ctl_1, ctl_3;
    logic [apdc_pkg::PIX_W-1:0]          dest_1, src_1, dest_3, src_3;
    logic [apdc_pkg::CHAN_W-1:0]         msk_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode       <= apdc_pkg::OP_OVER;
            r_use_const_src <= 1'b0;
            r_const_src     <= '0;
            r_use_const_msk <= 1'b0;
            r_const_msk     <= apdc_pkg::CHAN_MAX;
        end else if (i_cfg_valid) begin
            unique case (apdc_pkg::t_cfg_index'(i_cfg_index))
                apdc_pkg::CFG_OP_MODE:
                    r_op_mode <= apdc_pkg::t_op_mode'(i_cfg_data[1:0]);
                apdc_pkg::CFG_USE_CONST_SRC: r_use_const_src <= i_cfg_data[0];
                apdc_pkg::CFG_CONST_SRC:     r_const_src     <= i_cfg_data;
                apdc_pkg::CFG_USE_CONST_MSK: r_use_const_msk <= i_cfg_data[0];
                apdc_pkg::CFG_CONST_MSK:
                    r_const_msk <= i_cfg_data[apdc_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The pipeline moves whenever the output register is empty or being emptied.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    apdc_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (i_in_valid),
        .i_last          (i_last_in_run),
        .i_mode          (r_op_mode),
        .i_use_const_src (r_use_const_src),
        .i_const_src     (r_const_src),
        .i_use_const_msk (r_use_const_msk),
        .i_const_msk     (r_const_msk),
        .i_dest          (i_dest_pixel),
        .i_src           (i_source_pixel),
        .i_msk           (i_coverage),
        .o_ctl           (ctl_1),
        .o_dest          (dest_1),
        .o_src           (src_1),
        .o_msk           (msk_1)
    );

    apdc_mask_stage u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_1),
        .i_dest  (dest_1),
        .i_src   (src_1),
        .i_msk   (msk_1),
        .o_ctl   (ctl_3),
        .o_dest  (dest_3),
        .o_src   (src_3)
    );

    apdc_blend_stage u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_3),
        .i_dest  (dest_3),
        .i_src   (src_3),
        .o_valid (o_out_valid),
        .o_last  (o_last_out),
        .o_pixel (o_result_pixel)
    );

endmodule

FILE: src/apdc_in_stage.sv
// First pipeline stage: chooses per-beat or constant source and mask, registers them.
// Depends on apdc_pkg.
module apdc_in_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic                            i_last,
    input  apdc_pkg::t_op_mode              i_mode,
    input  logic                            i_use_const_src,
    input  logic [apdc_pkg::PIX_W-1:0]      i_const_src,
    input  logic                            i_use_const_msk,
    input  logic [apdc_pkg::CHAN_W-1:0]     i_const_msk,
    input  logic [apdc_pkg::PIX_W-1:0]      i_dest,
    input  logic [apdc_pkg::PIX_W-1:0]      i_src,
    input  logic [apdc_pkg::CHAN_W-1:0]     i_msk,
    output apdc_pkg::t_ctl                  o_ctl,
    output logic [apdc_pkg::PIX_W-1:0]      o_dest,
    output logic [apdc_pkg::PIX_W-1:0]      o_src,
    output logic [apdc_pkg::CHAN_W-1:0]     o_msk
);

    apdc_pkg::t_ctl                  r_ctl, n_ctl;
    logic [apdc_pkg::PIX_W-1:0]      r_dest, r_src, n_src;
    logic [apdc_pkg::CHAN_W-1:0]     r_msk, n_msk;

    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.last  = i_last;
        n_ctl.mode  = i_mode;
        n_src       = i_use_const_src ? i_const_src : i_src;
        n_msk       = i_use_const_msk ? i_const_msk : i_msk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dest     <= i_dest;
            r_src      <= n_src;
            r_msk      <= n_msk;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_dest = r_dest;
    assign o_src  = r_src;
    assign o_msk  = r_msk;

endmodule

FILE: src/apdc_mask_stage.sv
// Stages two and three: source times mask per channel, then the divide by 255.
// Picks the masked or the raw source for the blend. Depends on apdc_pkg.
module apdc_mask_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  apdc_pkg::t_ctl                  i_ctl,
    input  logic [apdc_pkg::PIX_W-1:0]      i_dest,
    input  logic [apdc_pkg::PIX_W-1:0]      i_src,
    input  logic [apdc_pkg::CHAN_W-1:0]     i_msk,
    output apdc_pkg::t_ctl                  o_ctl,
    output logic [apdc_pkg::PIX_W-1:0]      o_dest,
    output logic [apdc_pkg::PIX_W-1:0]      o_src
);

    apdc_pkg::t_ctl                  r_ctl_a, r_ctl_b;
    apdc_pkg::t_prod                 r_prod, n_prod;
    logic [apdc_pkg::PIX_W-1:0]      r_dest_a, r_src_a, r_dest_b, r_src_b;
    logic [apdc_pkg::PIX_W-1:0]      n_src_b;
    logic [apdc_pkg::PIX_W-1:0]      masked;

    always_comb begin
        for (int k = 0; k < apdc_pkg::NUM_CHAN; k++) begin
            n_prod[k] = {8'b0, i_src[k*apdc_pkg::CHAN_W +: apdc_pkg::CHAN_W]}
                      * {8'b0, i_msk};
        end
    end

    always_comb begin
        for (int k = 0; k < apdc_pkg::NUM_CHAN; k++) begin
            masked[k*apdc_pkg::CHAN_W +: apdc_pkg::CHAN_W] =
                apdc_pkg::sat8({1'b0, apdc_pkg::div255(r_prod[k])});
        end
        // IN and IN-then-OVER both continue with the masked source.
        if (r_ctl_a.mode == apdc_pkg::OP_IN || r_ctl_a.mode == apdc_pkg::OP_IN_OVER) begin
            n_src_b = masked;
        end else begin
            n_src_b = r_src_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= n_prod;
            r_dest_a     <= i_dest;
            r_src_a      <= i_src;
            r_dest_b     <= r_dest_a;
            r_src_b      <= n_src_b;
        end
    end

    assign o_ctl  = r_ctl_b;
    assign o_dest = r_dest_b;
    assign o_src  = r_src_b;

endmodule

FILE: src/apdc_blend_stage.sv
// Stages four and five: destination times source alpha, then OVER, ADD or IN
// with saturation into the output register. Depends on apdc_pkg.
module apdc_blend_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  apdc_pkg::t_ctl                  i_ctl,
    input  logic [apdc_pkg::PIX_W-1:0]      i_dest,
    input  logic [apdc_pkg::PIX_W-1:0]      i_src,
    output logic                            o_valid,
    output logic                            o_last,
    output logic [apdc_pkg::PIX_W-1:0]      o_pixel
);

    localparam int unsigned CW = apdc_pkg::CHAN_W;

    apdc_pkg::t_ctl                  r_ctl_a;
    apdc_pkg::t_prod                 r_prod, n_prod;
    logic [apdc_pkg::PIX_W-1:0]      r_dest_a, r_src_a;
    logic                            r_valid, r_last;
    logic [apdc_pkg::PIX_W-1:0]      r_pixel, n_pixel;
    logic [CW-1:0]                   dc, sc;
    logic [9:0]                      v_over, v_add;

    always_comb begin
        for (int k = 0; k < apdc_pkg::NUM_CHAN; k++) begin
            n_prod[k] = {8'b0, i_dest[k*CW +: CW]}
                      * {8'b0, i_src[apdc_pkg::PIX_W-1 -: CW]};
        end
    end

    // The scaled destination never exceeds the destination, so OVER cannot go negative.
    always_comb begin
        n_pixel = '0;
        dc      = '0;
        sc      = '0;
        v_over  = '0;
        v_add   = '0;
        for (int k = 0; k < apdc_pkg::NUM_CHAN; k++) begin
            dc     = r_dest_a[k*CW +: CW];
            sc     = r_src_a[k*CW +: CW];
            v_add  = {2'b0, dc} + {2'b0, sc};
            v_over = v_add - {1'b0, apdc_pkg::div255(r_prod[k])};
            unique case (r_ctl_a.mode)
                apdc_pkg::OP_IN:      n_pixel[k*CW +: CW] = sc;
                apdc_pkg::OP_ADD:     n_pixel[k*CW +: CW] = apdc_pkg::sat8(v_add);
                apdc_pkg::OP_OVER,
                apdc_pkg::OP_IN_OVER: n_pixel[k*CW +: CW] = apdc_pkg::sat8(v_over);
                default:              n_pixel[k*CW +: CW] = sc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_valid <= r_ctl_a.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod       <= n_prod;
            r_dest_a     <= i_dest;
            r_src_a      <= i_src;
            r_last       <= r_ctl_a.last;
            r_pixel      <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_pixel = r_pixel;

endmodule

FILE: src/apdc_checker.sv
// Port-level checks of the ARGB compositor, bound to the top level.
// Depends on argb_porter_duff_compositor_defines.svh and apdc_pkg.
`include "argb_porter_duff_compositor_defines.svh"

module apdc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [apdc_pkg::PIX_W-1:0]          o_result_pixel,
    input  logic                                o_last_out,
    input  logic                                o_cfg_ready
);

    logic out_stall;

    assign out_stall = o_out_valid && !i_out_ready;

    // A stalled result beat stays offered and keeps its value.
    `APDC_ASSERT(out_hold_a, out_stall |=> o_out_valid && $stable(o_last_out), "beat dropped")
    `APDC_ASSERT(out_data_a, out_stall |=> $stable(o_result_pixel), "stalled pixel changed")

    // Input back-pressure only comes from a stalled result.
    `APDC_ASSERT(in_stall_a, !o_in_ready |-> out_stall, "input stalled without output stall")

    `APDC_ASSERT_ALWAYS(rst_empty_a, !i_rst_n |=> !o_out_valid, "result valid right after reset")

    `APDC_ASSERT_ALWAYS(cfg_ready_a, o_cfg_ready, "configuration port not ready")

endmodule

bind argb_porter_duff_compositor apdc_checker u_apdc_checker (.*);

FILE: bench/argb_porter_duff_compositor_test.sv
// Self-checking testbench for the premultiplied ARGB compositor (IN, OVER, ADD, IN then OVER).
// Depends on apdc_pkg and argb_porter_duff_compositor; predicts every pixel and checks it.
module argb_porter_duff_compositor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int PIPE_LATENCY    = 5;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam int unsigned PIX_W      = apdc_pkg::PIX_W;
    localparam int unsigned CHAN_W     = apdc_pkg::CHAN_W;
    localparam int unsigned NUM_CHAN   = apdc_pkg::NUM_CHAN;
    localparam int unsigned CFG_IDX_W  = apdc_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = apdc_pkg::CFG_DATA_W;
    localparam logic [CHAN_W-1:0] CHAN_MAX = apdc_pkg::CHAN_MAX;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_blended;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_dest_pixel;
    logic [PIX_W-1:0]      i_source_pixel;
    logic [CHAN_W-1:0]     i_coverage;
    logic                  i_last_in_run;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIX_W-1:0]      o_result_pixel;
    logic                  o_last_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Register copy used by the pixel predictor.
    apdc_pkg::t_op_mode blend_mode;
    logic               const_src_en;
    logic [PIX_W-1:0]   const_src;
    logic               const_mask_en;
    logic [CHAN_W-1:0]  const_mask;

    t_blended pending_pixels[$];
    int       error_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_left;
    int       quiet_cycles;

    argb_porter_duff_compositor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_dest_pixel   (i_dest_pixel),
        .i_source_pixel (i_source_pixel),
        .i_coverage     (i_coverage),
        .i_last_in_run  (i_last_in_run),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_pixel (o_result_pixel),
        .o_last_out     (o_last_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------
    function automatic int unsigned div_by_255(input int unsigned x);
        return (x + (x >> 8)) >> 8;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input int unsigned v);
        return (v > 255) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] masked_pixel(input logic [PIX_W-1:0] src,
                                                      input logic [CHAN_W-1:0] m);
        logic [PIX_W-1:0] r;
        int unsigned      sc;
        for (int k = 0; k < NUM_CHAN; k++) begin
            sc = src[8*k +: 8];
            r[8*k +: 8] = clamp_chan(div_by_255(sc * m));
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] over_pixel(input logic [PIX_W-1:0] dst,
                                                    input logic [PIX_W-1:0] src);
        logic [PIX_W-1:0] r;
        int unsigned      alpha;
        int unsigned      dc;
        int unsigned      sc;
        alpha = src[31:24];
        for (int k = 0; k < NUM_CHAN; k++) begin
            dc = dst[8*k +: 8];
            sc = src[8*k +: 8];
            r[8*k +: 8] = clamp_chan(dc + sc - div_by_255(dc * alpha));
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] add_pixel(input logic [PIX_W-1:0] dst,
                                                   input logic [PIX_W-1:0] src);
        logic [PIX_W-1:0] r;
        int unsigned      dc;
        int unsigned      sc;
        for (int k = 0; k < NUM_CHAN; k++) begin
            dc = dst[8*k +: 8];
            sc = src[8*k +: 8];
            r[8*k +: 8] = clamp_chan(dc + sc);
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] composite_pixel(input logic [PIX_W-1:0] dst,
                                                         input logic [PIX_W-1:0] src_in,
                                                         input logic [CHAN_W-1:0] cov_in);
        logic [PIX_W-1:0]  src;
        logic [CHAN_W-1:0] cov;
        src = const_src_en ? const_src : src_in;
        cov = const_mask_en ? const_mask : cov_in;
        unique case (blend_mode)
            apdc_pkg::OP_IN:   return masked_pixel(src, cov);
            apdc_pkg::OP_OVER: return over_pixel(dst, src);
            apdc_pkg::OP_ADD:  return add_pixel(dst, src);
            default:           return over_pixel(dst, masked_pixel(src, cov));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random values, weighted toward the corners
    // ------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] px;
        logic [7:0]       alpha;
        case ($urandom_range(0, 7))
            0: px = '0;
            1: px = '1;
            2, 3, 4: px = $urandom;
            default: begin
                // Well-formed premultiplied pixel: no color above its alpha.
                alpha = $urandom_range(0, 255);
                px[31:24] = alpha;
                for (int k = 0; k < 3; k++)
                    px[8*k +: 8] = $urandom_range(0, alpha);
            end
        endcase
        return px;
    endfunction

    function automatic logic [CHAN_W-1:0] random_coverage();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CHAN_MAX;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        error_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_blended want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result beat with no pixel pending", o_result_pixel, '0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_result_pixel !== want.pixel)
                    report_mismatch("result_pixel", o_result_pixel, want.pixel);
                if (o_last_out !== want.last)
                    report_mismatch("last_out", PIX_W'(o_last_out), PIX_W'(want.last));
            end
        end
    end

    // The watchdog restarts on any accepted beat, on any of the three channels.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[argb_porter_duff_compositor] ERROR");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, or a long hold-off while hold_left runs down.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] dest, input logic [PIX_W-1:0] src,
                              input logic [CHAN_W-1:0] cov, input logic last);
        t_blended want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_dest_pixel   = dest;
        i_source_pixel = src;
        i_coverage     = cov;
        i_last_in_run  = last;
        do @(posedge i_clk); while (!o_in_ready);
        want.pixel = composite_pixel(dest, src, cov);
        want.last  = last;
        pending_pixels.push_back(want);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            apdc_pkg::CFG_OP_MODE:       blend_mode    = apdc_pkg::t_op_mode'(data[1:0]);
            apdc_pkg::CFG_USE_CONST_SRC: const_src_en  = data[0];
            apdc_pkg::CFG_CONST_SRC:     const_src     = data;
            apdc_pkg::CFG_USE_CONST_MSK: const_mask_en = data[0];
            apdc_pkg::CFG_CONST_MSK:     const_mask    = data[CHAN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Narrow registers get random junk above their used bits.
    task automatic load_config(input apdc_pkg::t_op_mode mode, input logic src_en,
                               input logic [PIX_W-1:0] src, input logic msk_en,
                               input logic [CHAN_W-1:0] msk);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[1:0] = mode;
        write_register(apdc_pkg::CFG_OP_MODE, data);
        data = $urandom;
        data[0] = src_en;
        write_register(apdc_pkg::CFG_USE_CONST_SRC, data);
        write_register(apdc_pkg::CFG_CONST_SRC, src);
        data = $urandom;
        data[0] = msk_en;
        write_register(apdc_pkg::CFG_USE_CONST_MSK, data);
        data = $urandom;
        data[CHAN_W-1:0] = msk;
        write_register(apdc_pkg::CFG_CONST_MSK, data);
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_IDX_W'($urandom_range(5, 7)), $urandom);
    endtask

    task automatic load_random_config(input apdc_pkg::t_op_mode mode);
        load_config(mode, $urandom_range(0, 3) == 0, random_pixel(),
                    $urandom_range(0, 2) == 0, random_coverage());
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel(), random_pixel(), random_coverage(),
                       1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves OVER selected with no constant overrides.
    task automatic test_reset_config();
        send_pixel('0, '0, '0, 1'b0);
        send_pixel('1, '1, CHAN_MAX, 1'b1);
        send_pixel(32'hffffffff, 32'h00ffffff, 8'h80, 1'b0);
        send_pixel(32'h80402010, 32'hff000000, 8'h00, 1'b1);
        send_pixel(32'ha5a5a5a5, 32'h5a5a5a5a, CHAN_MAX, 1'b0);
        wait_for_results();
    endtask

    task automatic test_each_operation();
        write_register(apdc_pkg::CFG_OP_MODE, CFG_DATA_W'(apdc_pkg::OP_IN));
        send_pixel('1, '1, CHAN_MAX, 1'b1);
        send_pixel('1, '1, '0, 1'b0);
        send_pixel('0, 32'h80808080, 8'h80, 1'b1);
        wait_for_results();
        write_register(apdc_pkg::CFG_OP_MODE, CFG_DATA_W'(apdc_pkg::OP_ADD));
        send_pixel('1, 32'h01010101, '0, 1'b0);
        send_pixel(32'h7f7f7f7f, 32'h80808080, 8'h55, 1'b1);
        wait_for_results();
        write_register(apdc_pkg::CFG_OP_MODE, CFG_DATA_W'(apdc_pkg::OP_IN_OVER));
        send_pixel('1, '1, CHAN_MAX, 1'b0);
        send_pixel(32'h80808080, 32'hff404040, '0, 1'b1);
        send_pixel('1, '1, 8'h80, 1'b0);
        wait_for_results();
    endtask

    // The constant mask and color are first used at their reset values.
    task automatic test_constant_overrides();
        write_register(apdc_pkg::CFG_OP_MODE, CFG_DATA_W'(apdc_pkg::OP_IN));
        write_register(apdc_pkg::CFG_USE_CONST_MSK, 32'd1);
        send_pixel('0, 32'h80ff4020, '0, 1'b0);
        wait_for_results();
        write_register(apdc_pkg::CFG_USE_CONST_SRC, 32'd1);
        send_pixel('1, '1, CHAN_MAX, 1'b1);
        wait_for_results();
        write_register(apdc_pkg::CFG_OP_MODE, CFG_DATA_W'(apdc_pkg::OP_IN_OVER));
        write_register(apdc_pkg::CFG_CONST_SRC, '1);
        write_register(apdc_pkg::CFG_CONST_MSK, '0);
        send_pixel(32'h12345678, 32'h9abcdef0, CHAN_MAX, 1'b0);
        wait_for_results();
        write_register(apdc_pkg::CFG_CONST_MSK, 32'hffffff00 | 32'(CHAN_MAX));
        send_pixel(32'h12345678, '0, '0, 1'b1);
        wait_for_results();
        // Writes to unused indexes must leave every register alone.
        write_register(CFG_IDX_W'(5), $urandom);
        write_register(CFG_IDX_W'(6), $urandom);
        write_register(CFG_IDX_W'(7), '1);
        send_pixel(32'h00ff7f01, '0, 8'h33, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int idle_phase;
        for (int seg = 0; seg < 24; seg++) begin
            if (seg < 16) begin
                load_random_config(apdc_pkg::t_op_mode'(seg % 4));
                idle_phase = (seg / 4) % 4;
            end else begin
                load_random_config(apdc_pkg::t_op_mode'($urandom_range(0, 3)));
                idle_phase = $urandom_range(0, 3);
            end
            case (idle_phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            send_random_pixels($urandom_range(60, 90));
            wait_for_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // The receiver holds off while the sender keeps offering, so the pipeline
    // fills and input beats must wait.
    task automatic test_backpressure();
        load_random_config(apdc_pkg::t_op_mode'($urandom_range(0, 3)));
        send_idle_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_OFF_CYCLES;
        send_random_pixels(40);
        wait_for_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_dest_pixel   = '0;
        i_source_pixel = '0;
        i_coverage     = '0;
        i_last_in_run  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        blend_mode     = apdc_pkg::OP_OVER;
        const_src_en   = 1'b0;
        const_src      = '0;
        const_mask_en  = 1'b0;
        const_mask     = CHAN_MAX;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config();
        test_each_operation();
        test_constant_overrides();
        test_random_traffic();
        test_backpressure();

        if (pending_pixels.size() != 0)
            report_mismatch("pixels never returned", '0, PIX_W'(pending_pixels.size()));
        if (error_count == 0) begin
            $display("[argb_porter_duff_compositor] OK");
        end else begin
            $display("[argb_porter_duff_compositor] ERROR");
        end
        $finish;
    end

endmodule

FILE: argb_porter_duff_compositor.f
+incdir+src
src/apdc_pkg.sv
src/apdc_in_stage.sv
src/apdc_mask_stage.sv
src/apdc_blend_stage.sv
src/argb_porter_duff_compositor.sv
src/apdc_checker.sv
bench/argb_porter_duff_compositor_test.sv
